// ----- rtl/ubd_pkg.sv -----
package ubd_pkg;

    localparam int ClkW  = 28;
    localparam int BaudW = 24;
    localparam int DenW  = BaudW + 2;
    localparam int RemW  = ClkW + 5;
    localparam int MantW = 12;
    localparam int QW    = 7;
    localparam int WordW = 16;

    localparam logic CFG_SLOW = 1'b0;
    localparam logic CFG_FAST = 1'b1;

    // Classified request, carried from the front to the back
    typedef struct packed {
        logic              err;
        logic              by8;
        logic [ClkW-1:0]   clk_hz;
        logic [BaudW-1:0]  baud;
    } ubd_item_t;

    // State of one divider pipeline stage
    typedef struct packed {
        logic              err;
        logic              by8;
        logic [ClkW-1:0]   num;
        logic [DenW-1:0]   den;
        logic [RemW-1:0]   rem;
        logic [MantW-1:0]  mant;
        logic [QW-1:0]     q2;
    } ubd_stage_t;

endpackage

// ----- rtl/ubd_front.sv -----
module ubd_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [ubd_pkg::BaudW-1:0] baud_rate,
    input  logic                      oversample_by_8,
    input  logic                      on_fast_bus,
    input  logic [ubd_pkg::ClkW-1:0]  slow_hz,
    input  logic [ubd_pkg::ClkW-1:0]  fast_hz,
    output logic                      f_valid,
    input  logic                      f_ready,
    output ubd_pkg::ubd_item_t        f_item
);
    import ubd_pkg::*;

    logic      valid_reg;
    ubd_item_t item_reg;
    ubd_item_t item_next;

    assign in_ready = !valid_reg || f_ready;

    // Classify: flag a zero rate, pick the bus clock
    always_comb
    begin
        item_next.err    = (baud_rate == '0);
        item_next.by8    = oversample_by_8;
        item_next.clk_hz = on_fast_bus ? fast_hz : slow_hz;
        item_next.baud   = baud_rate;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

    assign f_valid = valid_reg;
    assign f_item  = item_reg;
endmodule

// ----- rtl/ubd_queue.sv -----
module ubd_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_valid,
    output logic               wr_ready,
    input  ubd_pkg::ubd_item_t wr_item,
    output logic               rd_valid,
    input  logic               rd_ready,
    output ubd_pkg::ubd_item_t rd_item
);
    import ubd_pkg::*;

    ubd_item_t  mem_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_item  = mem_reg[rptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= !rptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= wr_item;
        end
    end
endmodule

// ----- rtl/ubd_back.sv -----
module ubd_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      b_valid,
    output logic                      b_ready,
    input  ubd_pkg::ubd_item_t        b_item,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [ubd_pkg::WordW-1:0] divisor_word,
    output logic                      rate_error
);
    import ubd_pkg::*;

    // load, ClkW mantissa steps, one scale, QW fraction steps
    localparam int NStg = 1 + ClkW + 1 + QW;

    logic             adv;
    logic             v_reg  [NStg];
    ubd_stage_t       st_reg [NStg];
    logic             ov_reg;
    logic [WordW-1:0] word_reg;
    logic             err_reg;
    logic [WordW-1:0] word_next;

    function automatic logic [3:0] frac_round(input logic [QW-1:0] r, input logic by8);
        logic [10:0] t;
        logic [23:0] p;
        logic [3:0]  f;
        if (by8)
        begin
            t = {1'b0, r, 3'b000} + 11'd50;
        end
        else
        begin
            t = {r, 4'b0000} + 11'd50;
        end
        // t/100 for t below 2048
        p = 24'(t) * 24'd5243;
        f = p[22:19];
        if (by8)
        begin
            f = f & 4'h7;
        end
        return f;
    endfunction

    assign adv     = !ov_reg || out_ready;
    assign b_ready = adv;

    genvar k;
    generate
        for (k = 0; k < NStg; k++)
        begin : g_stg
            if (k == 0)
            begin : g_load
                // Load: den is 2*baud (by8) or 4*baud; D4 = 4*den is formed per step from den
                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        st_reg[k].err  <= b_item.err;
                        st_reg[k].by8  <= b_item.by8;
                        st_reg[k].num  <= b_item.clk_hz;
                        st_reg[k].den  <= b_item.by8 ? {1'b0, b_item.baud, 1'b0}
                                                     : {b_item.baud, 2'b00};
                        st_reg[k].rem  <= '0;
                        st_reg[k].mant <= '0;
                        st_reg[k].q2   <= '0;
                    end
                end
                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                    begin
                        v_reg[k] <= 1'b0;
                    end
                    else if (adv)
                    begin
                        v_reg[k] <= b_valid;
                    end
                end
            end
            else
            begin : g_work
                ubd_stage_t s;
                ubd_stage_t n;
                assign s = st_reg[k-1];
                if (k <= ClkW)
                begin : g_mant
                    // One bit of clk / (4*D): mantissa and remainder R
                    logic [ClkW:0]   r2;
                    logic [ClkW:0]   d4;
                    always_comb
                    begin
                        n      = s;
                        r2     = {s.rem[ClkW-1:0], s.num[ClkW-1]};
                        d4     = {1'b0, s.den, 2'b00};
                        n.num  = {s.num[ClkW-2:0], 1'b0};
                        if (r2 >= d4)
                        begin
                            n.rem  = RemW'(r2 - d4);
                            n.mant = {s.mant[MantW-2:0], 1'b1};
                        end
                        else
                        begin
                            n.rem  = RemW'(r2);
                            n.mant = {s.mant[MantW-2:0], 1'b0};
                        end
                    end
                end
                else if (k == ClkW + 1)
                begin : g_scale
                    // Scale remainder by 25
                    always_comb
                    begin
                        n     = s;
                        n.rem = {s.rem[ClkW-1:0], 5'b0} - {2'b0, s.rem[ClkW-1:0], 3'b0}
                                + {5'b0, s.rem[ClkW-1:0]};
                    end
                end
                else
                begin : g_frac
                    // One bit of 25R / D: hundredths of the divisor
                    localparam int Sh = NStg - 1 - k;
                    logic [RemW-1:0] dsh;
                    always_comb
                    begin
                        n   = s;
                        dsh = RemW'(s.den) << Sh;
                        if (s.rem >= dsh)
                        begin
                            n.rem    = s.rem - dsh;
                            n.q2[Sh] = 1'b1;
                        end
                    end
                end
                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        st_reg[k] <= n;
                    end
                end
                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                    begin
                        v_reg[k] <= 1'b0;
                    end
                    else if (adv)
                    begin
                        v_reg[k] <= v_reg[k-1];
                    end
                end
            end
        end
    endgenerate

    // Assemble the word, force zero on a rate error
    always_comb
    begin
        if (st_reg[NStg-1].err)
        begin
            word_next = '0;
        end
        else
        begin
            word_next = {st_reg[NStg-1].mant,
                         frac_round(st_reg[NStg-1].q2, st_reg[NStg-1].by8)};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (adv)
        begin
            ov_reg <= v_reg[NStg-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            word_reg <= word_next;
            err_reg  <= st_reg[NStg-1].err;
        end
    end

    assign out_valid    = ov_reg;
    assign divisor_word = word_reg;
    assign rate_error   = err_reg;
endmodule

// ----- rtl/uart_baud_divisor_calc_top.sv -----
// Throughput: one item per cycle unless out_ready stalls it; the bit-serial divider pipeline
// (28 mantissa steps, 7 fraction steps) takes a new item every cycle while not stalled.
// Reset (rst_n low, asynchronous): all pipeline and queue valids clear,
// bus clock registers return to 36000000 and 72000000 Hz.
module uart_baud_divisor_calc_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [ubd_pkg::ClkW-1:0]  cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [ubd_pkg::BaudW-1:0] baud_rate,
    input  logic                      oversample_by_8,
    input  logic                      on_fast_bus,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [ubd_pkg::WordW-1:0] divisor_word,
    output logic                      rate_error
);
    import ubd_pkg::*;

    logic [ClkW-1:0] slow_hz_reg;
    logic [ClkW-1:0] fast_hz_reg;
    logic            f_valid;
    logic            f_ready;
    ubd_item_t       f_item;
    logic            b_valid;
    logic            b_ready;
    ubd_item_t       b_item;

    // Hold bus clock frequencies
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slow_hz_reg <= ClkW'(36000000);
            fast_hz_reg <= ClkW'(72000000);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SLOW: slow_hz_reg <= cfg_data;
                CFG_FAST: fast_hz_reg <= cfg_data;
                default:  slow_hz_reg <= slow_hz_reg;
            endcase
        end
    end

    ubd_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .baud_rate       (baud_rate),
        .oversample_by_8 (oversample_by_8),
        .on_fast_bus     (on_fast_bus),
        .slow_hz         (slow_hz_reg),
        .fast_hz         (fast_hz_reg),
        .f_valid         (f_valid),
        .f_ready         (f_ready),
        .f_item          (f_item)
    );

    ubd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_item  (f_item),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_item  (b_item)
    );

    ubd_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .b_valid      (b_valid),
        .b_ready      (b_ready),
        .b_item       (b_item),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .divisor_word (divisor_word),
        .rate_error   (rate_error)
    );
endmodule
